### rtl/cbs_server_state_machine_core_assert.svh
// ----------------------------------------------------------------------------
// cbs server assertion macros
// Shared property forms for the server checker.
// ----------------------------------------------------------------------------
`ifndef CBS_SERVER_STATE_MACHINE_CORE_ASSERT_SVH
`define CBS_SERVER_STATE_MACHINE_CORE_ASSERT_SVH

// implication checked at every clock edge outside reset
`define CBS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbs server check failed");

// next-cycle implication checked outside reset
`define CBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbs server check failed");

// condition that must never be seen outside reset
`define CBS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("cbs server check failed");

`endif

### rtl/cbs_ssm_pkg.sv
// ----------------------------------------------------------------------------
// cbs_ssm_pkg
// Types, codes and widths shared by the constant bandwidth server core.
// ----------------------------------------------------------------------------
package cbs_ssm_pkg;

  // field widths
  localparam int TIME_BITS     = 32;
  localparam int TAG_BITS      = 16;
  localparam int FUNC_BITS     = 4;
  localparam int QCNT_BITS     = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  // default job queue depth
  localparam int DEF_QUEUE_DEPTH = 16;

  // event codes
  localparam logic [FUNC_BITS-1:0] FUNC_ENQUEUE    = 4'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_DEQUEUE    = 4'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_ACTIVATE   = 4'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_DISPATCH   = 4'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_PREEMPT    = 4'd4;
  localparam logic [FUNC_BITS-1:0] FUNC_COMPLETE   = 4'd5;
  localparam logic [FUNC_BITS-1:0] FUNC_EXHAUST    = 4'd6;
  localparam logic [FUNC_BITS-1:0] FUNC_REACTIVATE = 4'd7;
  localparam logic [FUNC_BITS-1:0] FUNC_NONCONTEND = 4'd8;
  localparam logic [FUNC_BITS-1:0] FUNC_DEADLINE   = 4'd9;
  localparam logic [FUNC_BITS-1:0] FUNC_VTIME      = 4'd10;
  localparam logic [FUNC_BITS-1:0] FUNC_CONSUME    = 4'd11;

  // server states
  localparam logic [1:0] SRV_INACTIVE = 2'd0;
  localparam logic [1:0] SRV_READY    = 2'd1;
  localparam logic [1:0] SRV_RUNNING  = 2'd2;
  localparam logic [1:0] SRV_NONCONT  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ILLEGAL = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  // overrun policies
  localparam logic [1:0] POL_QUEUE = 2'd0;
  localparam logic [1:0] POL_SKIP  = 2'd1;
  localparam logic [1:0] POL_ABORT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_BUDGET = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY = 2'd2;

  // configuration reset values
  localparam logic [TIME_BITS-1:0] RST_BUDGET = 32'd1000;
  localparam logic [TIME_BITS-1:0] RST_PERIOD = 32'd10000;

  // input item
  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [TIME_BITS-1:0] time_now;
    logic [TIME_BITS-1:0] amount;
    logic [TAG_BITS-1:0]  job_tag;
  } cbs_in_t;

  // result item
  typedef struct packed {
    logic [1:0]           server_state;
    logic [TIME_BITS-1:0] deadline;
    logic [TIME_BITS-1:0] virtual_time;
    logic [TIME_BITS-1:0] budget_left;
    logic [QCNT_BITS-1:0] queue_count;
    logic                 head_valid;
    logic [TAG_BITS-1:0]  head_tag;
    logic [TAG_BITS-1:0]  taken_tag;
    logic [TIME_BITS-1:0] last_job_id;
    logic                 job_skipped;
    logic [1:0]           status;
  } cbs_out_t;

endpackage

### rtl/cbs_server_state_machine_core.sv
// ----------------------------------------------------------------------------
// cbs_server_state_machine_core
// Constant bandwidth server for one reservation with a bounded job queue.
// ----------------------------------------------------------------------------
// One item is taken when start is high and busy is low; exactly one result
// follows on result, marked by a single-cycle done strobe that cannot be held
// off. Most events pass through S_EXEC, S_READ and S_PACK before done, and
// a new item can be taken in the cycle that done is shown, as busy is then low.
// The virtual-time event goes through one registered 32x32 multiply, a
// restoring divider that resolves one quotient bit per cycle over the
// 2*TIME_BITS-bit product, and an add, before S_READ and S_PACK.
// Configuration writes are always ready and are meant to be made while the
// block is idle.
// ----------------------------------------------------------------------------
module cbs_server_state_machine_core
  import cbs_ssm_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  cbs_in_t                  cmd,
  output logic                     done,
  output cbs_out_t                 result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W = 2 * TIME_BITS;
  localparam int DCNT_W = $clog2(PROD_W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_DIV  = 6'b000100,
    S_VADD = 6'b001000,
    S_READ = 6'b010000,
    S_PACK = 6'b100000
  } seq_state_t;

  seq_state_t seq_state;

  // configuration
  logic [TIME_BITS-1:0] server_budget;
  logic [TIME_BITS-1:0] server_period;
  logic [1:0]           overrun_policy;

  // server state
  logic [1:0]           srv_state;
  logic [TIME_BITS-1:0] deadline_reg;
  logic [TIME_BITS-1:0] vtime_reg;
  logic [TIME_BITS-1:0] budget_reg;
  logic [TIME_BITS-1:0] job_seq;

  // job queue
  logic [TAG_BITS-1:0]  job_fifo [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]  rd_data;
  logic [PTR_W-1:0]     fifo_head;
  logic [PTR_W-1:0]     fifo_tail;
  logic [CNT_W-1:0]     fifo_count;
  logic [PTR_W-1:0]     head_inc;
  logic [PTR_W-1:0]     tail_inc;

  // latched item and per-event flags
  cbs_in_t              item_q;
  logic [1:0]           status_q;
  logic                 skipped_q;
  logic [TAG_BITS-1:0]  taken_q;

  // divider
  logic [TIME_BITS-1:0] div_rem;
  logic [PROD_W-1:0]    div_pq;
  logic [DCNT_W-1:0]    div_cnt;
  logic [TIME_BITS:0]   rem_sh;
  logic [TIME_BITS+1:0] rem_diff;
  logic                 q_bit;

  // enqueue decision
  logic                 enq_overrun;
  logic                 enq_skip;
  logic                 enq_drop;
  logic [CNT_W-1:0]     cnt_after;
  logic                 enq_full;
  logic                 fifo_we;

  assign busy      = (seq_state != S_IDLE);
  assign cfg_ready = 1'b1;

  // pointer wrap
  always_comb begin
    head_inc = (fifo_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : fifo_head + 1'b1;
    tail_inc = (fifo_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : fifo_tail + 1'b1;
  end

  // overrun policy and queue room for an enqueue
  always_comb begin
    enq_overrun = (srv_state == SRV_RUNNING) && (fifo_count != '0);
    enq_skip    = enq_overrun && (overrun_policy == POL_SKIP);
    enq_drop    = enq_overrun && (overrun_policy == POL_ABORT);
    cnt_after   = fifo_count - CNT_W'(enq_drop);
    enq_full    = (cnt_after >= CNT_W'(QUEUE_DEPTH));
    fifo_we     = (seq_state == S_EXEC) && (item_q.func == FUNC_ENQUEUE) &&
                  !enq_skip && !enq_full;
  end

  // one restoring division step
  always_comb begin
    rem_sh   = {div_rem, div_pq[PROD_W-1]};
    rem_diff = {1'b0, rem_sh} - {2'b00, server_budget};
    q_bit    = !rem_diff[TIME_BITS+1];
  end

  // queue storage, registered read at the head
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      job_fifo[fifo_tail] <= item_q.job_tag;
    end
    rd_data <= job_fifo[fifo_head];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      server_budget  <= RST_BUDGET;
      server_period  <= RST_PERIOD;
      overrun_policy <= POL_QUEUE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BUDGET: server_budget  <= cfg_data[TIME_BITS-1:0];
        CFG_PERIOD: server_period  <= cfg_data[TIME_BITS-1:0];
        CFG_POLICY: overrun_policy <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= cmd;
    end
  end

  // sequencer and server state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state    <= S_IDLE;
      srv_state    <= SRV_INACTIVE;
      deadline_reg <= '0;
      vtime_reg    <= '0;
      budget_reg   <= RST_BUDGET;
      job_seq      <= '0;
      fifo_head    <= '0;
      fifo_tail    <= '0;
      fifo_count   <= '0;
      div_cnt      <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (seq_state)
        S_IDLE: begin
          if (start) begin
            seq_state <= S_EXEC;
          end
        end

        S_EXEC: begin
          status_q  <= STAT_OK;
          skipped_q <= 1'b0;
          taken_q   <= '0;
          seq_state <= S_READ;
          case (item_q.func)
            FUNC_ENQUEUE: begin
              if (enq_skip) begin
                skipped_q <= 1'b1;
              end else if (enq_full) begin
                status_q <= STAT_FULL;
              end else begin
                if (enq_drop) begin
                  fifo_head <= head_inc;
                end
                fifo_tail  <= tail_inc;
                fifo_count <= cnt_after + 1'b1;
                job_seq    <= job_seq + 1'b1;
              end
            end
            FUNC_DEQUEUE: begin
              if (fifo_count == '0) begin
                status_q <= STAT_EMPTY;
              end else begin
                taken_q    <= rd_data;
                fifo_head  <= head_inc;
                fifo_count <= fifo_count - 1'b1;
              end
            end
            FUNC_ACTIVATE: begin
              if (srv_state != SRV_INACTIVE || fifo_count == '0) begin
                status_q <= STAT_ILLEGAL;
              end else begin
                vtime_reg    <= item_q.time_now;
                deadline_reg <= item_q.time_now + server_period;
                budget_reg   <= server_budget;
                srv_state    <= SRV_READY;
              end
            end
            FUNC_DISPATCH: begin
              if (srv_state != SRV_READY || fifo_count == '0) begin
                status_q <= STAT_ILLEGAL;
              end else begin
                srv_state <= SRV_RUNNING;
              end
            end
            FUNC_PREEMPT, FUNC_COMPLETE, FUNC_EXHAUST, FUNC_NONCONTEND: begin
              if (srv_state != SRV_RUNNING) begin
                status_q <= STAT_ILLEGAL;
              end else if (item_q.func == FUNC_PREEMPT) begin
                srv_state <= SRV_READY;
              end else if (item_q.func == FUNC_COMPLETE) begin
                srv_state <= (fifo_count != '0) ? SRV_READY : SRV_INACTIVE;
              end else if (item_q.func == FUNC_EXHAUST) begin
                deadline_reg <= deadline_reg + server_period;
                budget_reg   <= server_budget;
                srv_state    <= SRV_READY;
              end else begin
                srv_state <= SRV_NONCONT;
              end
            end
            FUNC_REACTIVATE, FUNC_DEADLINE: begin
              if (srv_state != SRV_NONCONT) begin
                status_q <= STAT_ILLEGAL;
              end else begin
                srv_state <= (item_q.func == FUNC_REACTIVATE) ? SRV_READY
                                                              : SRV_INACTIVE;
              end
            end
            FUNC_VTIME: begin
              // product feeds the divider
              div_pq    <= PROD_W'(item_q.amount) * PROD_W'(server_period);
              div_rem   <= '0;
              div_cnt   <= DCNT_W'(PROD_W - 1);
              seq_state <= S_DIV;
            end
            FUNC_CONSUME: begin
              budget_reg <= (item_q.amount >= budget_reg) ? '0
                                                          : budget_reg - item_q.amount;
            end
            default: begin
              status_q <= STAT_ILLEGAL;
            end
          endcase
        end

        S_DIV: begin
          // one quotient bit per cycle, most significant first
          div_rem <= q_bit ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
          div_pq  <= {div_pq[PROD_W-2:0], q_bit};
          if (div_cnt == '0) begin
            seq_state <= S_VADD;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end

        S_VADD: begin
          vtime_reg <= vtime_reg + div_pq[TIME_BITS-1:0];
          seq_state <= S_READ;
        end

        S_READ: begin
          // head entry read lands in rd_data
          seq_state <= S_PACK;
        end

        S_PACK: begin
          done      <= 1'b1;
          seq_state <= S_IDLE;
        end

        default: begin
          seq_state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (seq_state == S_PACK) begin
      result.server_state <= srv_state;
      result.deadline     <= deadline_reg;
      result.virtual_time <= vtime_reg;
      result.budget_left  <= budget_reg;
      result.queue_count  <= QCNT_BITS'(fifo_count);
      result.head_valid   <= (fifo_count != '0);
      result.head_tag     <= (fifo_count != '0) ? rd_data : '0;
      result.taken_tag    <= taken_q;
      result.last_job_id  <= job_seq;
      result.job_skipped  <= skipped_q;
      result.status       <= status_q;
    end
  end

endmodule

### rtl/cbs_ssm_checker.sv
// ----------------------------------------------------------------------------
// cbs_ssm_checker
// Port-level checks on the server core, bound to cbs_server_state_machine_core.
// ----------------------------------------------------------------------------
`include "cbs_server_state_machine_core_assert.svh"

module cbs_ssm_checker
  import cbs_ssm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input cbs_out_t result
);

  // an accepted item keeps the block busy next cycle
  `CBS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // a result strobe lasts a single cycle
  `CBS_ASSERT_NEXT(a_done_single, done, !done)

  // results are shown only once the block is free
  `CBS_ASSERT_NEVER(a_done_idle, done && busy)

  // head valid follows the queue count
  `CBS_ASSERT_IMPL(a_head_valid, done, result.head_valid == (result.queue_count != '0))

  // a taken tag comes only with a good status
  `CBS_ASSERT_IMPL(a_taken_ok, done && (result.status != STAT_OK), result.taken_tag == '0)

endmodule

bind cbs_server_state_machine_core cbs_ssm_checker u_cbs_ssm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
